/* hw/rtl/saq_pkg.sv */
// Shared types and constants for the sorted alarm queue.
package saq_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Input mode codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic ins_en;  // an insert lands in the row this cycle
    logic occ;     // this slot holds a stored entry
  } cell_ctl_t;

  // Per-cell status handed to the right neighbor and the controller
  typedef struct packed {
    logic take;    // new value belongs at or before this slot
  } cell_stat_t;

endpackage

/* hw/rtl/saq_if.sv */
// Handshake channel interfaces for the input and result words.
interface saq_in_if #(
  parameter int VALUE_WIDTH = 24
) ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface saq_out_if #(
  parameter int VALUE_WIDTH = 24,
  parameter int SLOT_WIDTH  = 4,
  parameter int COUNT_WIDTH = 4
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [VALUE_WIDTH-1:0] popped_value;
  logic [SLOT_WIDTH-1:0]  insert_slot;
  logic [COUNT_WIDTH-1:0] entry_count;

  modport source (output valid, status, popped_value, insert_slot, entry_count, input ready);
  modport sink   (input valid, status, popped_value, insert_slot, entry_count, output ready);
endinterface

/* hw/rtl/saq_cell.sv */
// One slot of the sorted row: compare against the new value and shift right.
module saq_cell #(
  parameter int VALUE_WIDTH = 24
) (
  input  logic                   clk,
  input  saq_pkg::cell_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  saq_pkg::cell_stat_t    left_stat,
  input  logic [VALUE_WIDTH-1:0] left_entry,
  output saq_pkg::cell_stat_t    stat,
  output logic [VALUE_WIDTH-1:0] entry
);

  logic [VALUE_WIDTH-1:0] entry_r;
  logic [VALUE_WIDTH-1:0] entry_nxt;

  // Empty slots and strictly smaller entries sit behind the new value
  assign stat.take = !ctl.occ || (new_value > entry_r);
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && stat.take) begin
      // Boundary slot takes the new value, later slots take the left neighbor
      entry_nxt = left_stat.take ? left_entry : new_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* hw/rtl/saq_obuf.sv */
// Result register with a skid stage so input and output stalls are decoupled.
module saq_obuf #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [WIDTH-1:0] out_d_r, out_d_nxt;
  logic [WIDTH-1:0] skid_d_r, skid_d_nxt;
  logic             acc;
  logic             drain;

  assign in_ready  = !skid_v_r;
  assign acc       = in_valid && in_ready;
  assign drain     = out_v_r && out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || drain) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else if (acc) begin
        out_v_nxt = 1'b1;
        out_d_nxt = in_data;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (acc) begin
      // Output stalled: park the word in the skid stage
      skid_v_nxt = 1'b1;
      skid_d_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

/* hw/rtl/sorted_alarm_queue_top.sv */
// Top level of the sorted alarm queue: controller, row of cells and result buffer.
//
//   channel   | role   | word contents
//   ----------+--------+-----------------------------------------------------
//   in_chan   | sink   | mode (0 insert, 1 pop), value
//   out_chan  | source | status, popped_value, insert_slot, entry_count
//
// One word is taken per cycle while the buffer accepts; its result is registered
// in the output register, or in the skid stage while the output is stalled. The
// row of cells compares combinationally, so only registered state links consecutive words.
// A two-deep result buffer keeps accepting while one result waits; input
// stalls only when both buffer stages are full.
// Synchronous active-low reset clears the count and the buffer valids; the
// cell contents are left as they are and read only below the count.
module sorted_alarm_queue_top #(
  parameter int DEPTH       = 10,
  parameter int VALUE_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  saq_in_if.sink     in_chan,
  saq_out_if.source  out_chan
);

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = 2 + VALUE_WIDTH + SW + CW;

  logic [CW-1:0] count_r, count_nxt;

  logic                     acc;
  logic                     is_full;
  logic                     is_empty;
  logic                     ins_ok;
  logic                     buf_ready;

  logic [DEPTH:0]           occ;        // occ[DEPTH] is a constant zero guard
  saq_pkg::cell_ctl_t       ctl   [DEPTH];
  saq_pkg::cell_stat_t      stat  [DEPTH];
  logic [VALUE_WIDTH-1:0]   entry [DEPTH];
  saq_pkg::cell_stat_t      left_stat  [DEPTH];
  logic [VALUE_WIDTH-1:0]   left_entry [DEPTH];

  logic [1:0]               res_status;
  logic [VALUE_WIDTH-1:0]   res_popped;
  logic [SW-1:0]            res_slot;
  logic [VALUE_WIDTH-1:0]   tail_value;
  logic [SW-1:0]            ins_slot;
  logic [RW-1:0]            res_word;
  logic [RW-1:0]            out_word;

  assign in_chan.ready = buf_ready;
  assign acc      = in_chan.valid && buf_ready;
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign ins_ok   = acc && (in_chan.mode == saq_pkg::MODE_INSERT) && !is_full;

  // Occupancy thermometer from the count
  assign occ[DEPTH] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign occ[gi]        = (CW'(gi) < count_r);
      assign ctl[gi].ins_en = ins_ok;
      assign ctl[gi].occ    = occ[gi];

      if (gi == 0) begin : g_head
        assign left_stat[gi].take = 1'b0;
        assign left_entry[gi]     = in_chan.value;
      end else begin : g_link
        assign left_stat[gi]  = stat[gi-1];
        assign left_entry[gi] = entry[gi-1];
      end

      saq_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl[gi]),
        .new_value  (in_chan.value),
        .left_stat  (left_stat[gi]),
        .left_entry (left_entry[gi]),
        .stat       (stat[gi]),
        .entry      (entry[gi])
      );
    end
  endgenerate

  // Landing slot is where take first goes high; tail is the last occupied
  // slot. Each marks at most one slot of the row, so OR-reduce them.
  always_comb begin
    ins_slot   = '0;
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (stat[i].take && !left_stat[i].take) begin
        ins_slot = ins_slot | SW'(i);
      end
      if (occ[i] && !occ[i+1]) begin
        tail_value = tail_value | entry[i];
      end
    end
  end

  // Build the result word and the next count
  always_comb begin
    res_status = saq_pkg::ST_OK;
    res_popped = '0;
    res_slot   = '0;
    count_nxt  = count_r;
    if (in_chan.mode == saq_pkg::MODE_INSERT) begin
      if (is_full) begin
        res_status = saq_pkg::ST_FULL;
      end else begin
        res_slot  = ins_slot;
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (is_empty) begin
        res_status = saq_pkg::ST_EMPTY;
      end else begin
        res_popped = tail_value;
        count_nxt  = count_r - CW'(1);
      end
    end
  end

  assign res_word = {res_status, res_popped, res_slot, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

  saq_obuf #(
    .WIDTH(RW)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (buf_ready),
    .in_data   (res_word),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_word)
  );

  assign out_chan.status       = out_word[RW-1 -: 2];
  assign out_chan.popped_value = out_word[RW-3 -: VALUE_WIDTH];
  assign out_chan.insert_slot  = out_word[CW +: SW];
  assign out_chan.entry_count  = out_word[CW-1:0];

endmodule

/* hw/rtl/saq_chk.sv */
// Port-level checker for the sorted alarm queue, bound to the top level.
module saq_chk #(
  parameter int DEPTH       = 10,
  parameter int VALUE_WIDTH = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic [VALUE_WIDTH-1:0]        popped_value,
  input logic [$clog2(DEPTH)-1:0]      insert_slot,
  input logic [$clog2(DEPTH+1)-1:0]    entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  // Hold the status and count of a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("saq: stalled result changed");

  // Reject an insert only when the queue is at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == saq_pkg::ST_FULL |-> entry_count == CW'(DEPTH) && insert_slot == '0)
    else $error("saq: full status with queue not full");

  // Report empty pops with a zero count and no value
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == saq_pkg::ST_EMPTY |-> entry_count == '0 && popped_value == '0)
    else $error("saq: empty status inconsistent");

  // An insert lands no further than one slot past the old tail
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == saq_pkg::ST_OK && entry_count != '0 |->
      CW'(insert_slot) < entry_count)
    else $error("saq: insert slot past tail");

endmodule

bind sorted_alarm_queue_top saq_chk #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_saq_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .popped_value (out_chan.popped_value),
  .insert_slot  (out_chan.insert_slot),
  .entry_count  (out_chan.entry_count)
);
